// ===== hw/rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types and constants of the linear probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int HASH_W  = 32;
	localparam int FIELD_W = 32;
	localparam int LIVE_W  = 9;
	localparam int MODE_W  = 2;
	localparam int IN_W    = 96;
	localparam int OUT_W   = 48;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MOD   = 5'b00010,
		ST_PROBE = 5'b00100,
		ST_ACT   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

endpackage

// ===== hw/rtl/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing key/value table with linear probing, one request at a time
// ----------------------------------------------------------------------------
// requests enter on the s_axis channel: tuser carries the mode (lookup,
// insert or update, remove, clear), tdata the hash, key and value. every
// request returns one word on the m_axis channel with status, hit, added,
// the looked-up value and the live entry count after the request.
// the probe walks one bucket per cycle through a single ram read port and
// one hash/key comparator; the ram read is registered, so each bucket is
// checked on the registered read data. the start bucket is taken straight
// from the hash when CAPACITY is a power of two; otherwise it comes from a
// reciprocal multiplication and a remainder step. clear skips the probe.
// s_axis_tready is high only while the sequencer is idle. the result sits in
// an output register, so the next request is taken while it waits; a stalled
// receiver holds a finished request until the register frees up.
// reset empties the table at once through per-bucket valid flops, no sweep.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
	parameter int CAPACITY    = 256,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// hash_code, key, value
	input  logic [lpht_pkg::IN_W-1:0]  s_axis_tdata,
	// mode
	input  logic [lpht_pkg::MODE_W-1:0] s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status, hit, added, value_out, live_entries, zero fill
	output logic [lpht_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int IDXW    = $clog2(CAPACITY);
	localparam int CNTW    = $clog2(CAPACITY + 1);
	localparam int WORDW   = 1 + lpht_pkg::HASH_W + KEY_WIDTH + VALUE_WIDTH;
	localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
	localparam logic [64:0] RECIP =
		((65'd1 << (32 + IDXW)) + 65'(CAPACITY - 1)) / 65'(CAPACITY);
	localparam logic [31:0] RECIP_LO = RECIP[31:0];

	lpht_pkg::state_t  st_q;
	lpht_pkg::mode_t   mode_q;
	logic [lpht_pkg::HASH_W-1:0] hash_q;
	logic [KEY_WIDTH-1:0]        key_q;
	logic [VALUE_WIDTH-1:0]      val_q;

	logic [1:0]         step_q;
	logic [31:0]        mulhi_q;
	logic [31:0]        quo_q;
	logic [63:0]        mul_full;
	logic [32:0]        quo_sum;
	logic [IDXW-1:0]    quo_mul;

	logic [IDXW-1:0]    rd_addr_q;
	logic [IDXW-1:0]    n_chk_q;
	logic               pend_s1;
	logic [IDXW-1:0]    addr_s1;
	logic               vbit_s1;
	logic               have_tomb_q;
	logic [IDXW-1:0]    tomb_addr_q;

	logic               present_q;
	logic               can_put_q;
	logic [IDXW-1:0]    tgt_addr_q;
	logic [WORDW-1:0]   word_q;

	logic [CAPACITY-1:0] valid_q;
	logic [CNTW-1:0]     cnt_q;

	lpht_pkg::status_t   res_status_q;
	logic                res_hit_q;
	logic                res_added_q;
	logic [lpht_pkg::FIELD_W-1:0] res_vout_q;

	logic                out_valid_q;
	lpht_pkg::status_t   status_q;
	logic                hit_q;
	logic                added_q;
	logic [lpht_pkg::FIELD_W-1:0] vout_q;
	logic [lpht_pkg::LIVE_W-1:0]  live_q;

	logic [WORDW-1:0]    rdata;
	logic                r_tomb;
	logic [lpht_pkg::HASH_W-1:0] r_hash;
	logic [KEY_WIDTH-1:0]        r_key;
	logic                b_empty;
	logic                b_tomb;
	logic                b_match;
	logic                b_last;
	logic                done_probe;
	logic                issue;
	logic [IDXW-1:0]     rd_addr_inc;

	logic                ram_we;
	logic [WORDW-1:0]    ram_wdata;
	logic                in_fire;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	assign r_tomb = rdata[WORDW-1];
	assign r_hash = rdata[VALUE_WIDTH + KEY_WIDTH +: lpht_pkg::HASH_W];
	assign r_key  = rdata[VALUE_WIDTH +: KEY_WIDTH];

	assign b_empty    = pend_s1 && !vbit_s1;
	assign b_tomb     = pend_s1 && vbit_s1 && r_tomb;
	assign b_match    = pend_s1 && vbit_s1 && !r_tomb && (r_hash == hash_q) && (r_key == key_q);
	assign b_last     = pend_s1 && (n_chk_q == IDXW'(CAPACITY - 1));
	assign done_probe = b_empty || b_match || b_last;
	assign issue      = (st_q == lpht_pkg::ST_PROBE) && !done_probe;

	assign rd_addr_inc = (rd_addr_q == IDXW'(CAPACITY - 1)) ? '0 : rd_addr_q + 1'b1;

	// start bucket by reciprocal multiplication for other capacities
	assign mul_full = 64'(hash_q) * 64'(RECIP_LO);
	assign quo_sum  = {1'b0, hash_q} + {1'b0, mulhi_q};
	assign quo_mul  = quo_q[IDXW-1:0] * IDXW'(CAPACITY);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {1'b0, hash_q, key_q, val_q};
		if (st_q == lpht_pkg::ST_ACT) begin
			case (mode_q)
				lpht_pkg::MODE_INSERT: begin
					ram_we = present_q || can_put_q;
				end
				lpht_pkg::MODE_REMOVE: begin
					ram_we    = present_q;
					ram_wdata = {1'b1, word_q[WORDW-2:0]};
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	lpht_ram #(
		.WIDTH(WORDW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tgt_addr_q),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	// sequencer and bucket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= lpht_pkg::ST_IDLE;
			valid_q      <= '0;
			cnt_q        <= '0;
			pend_s1      <= 1'b0;
			have_tomb_q  <= 1'b0;
			step_q       <= '0;
			n_chk_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (st_q == lpht_pkg::ST_OUT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				lpht_pkg::ST_IDLE: begin
					if (in_fire) begin
						pend_s1     <= 1'b0;
						have_tomb_q <= 1'b0;
						n_chk_q     <= '0;
						step_q      <= '0;
						if (lpht_pkg::mode_t'(s_axis_tuser) == lpht_pkg::MODE_CLEAR) begin
							valid_q <= '0;
							cnt_q   <= '0;
							st_q    <= lpht_pkg::ST_OUT;
						end else if (IS_POW2) begin
							st_q <= lpht_pkg::ST_PROBE;
						end else begin
							st_q <= lpht_pkg::ST_MOD;
						end
					end
				end
				lpht_pkg::ST_MOD: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2) begin
						st_q <= lpht_pkg::ST_PROBE;
					end
				end
				lpht_pkg::ST_PROBE: begin
					pend_s1 <= issue;
					if (b_tomb && !have_tomb_q) begin
						have_tomb_q <= 1'b1;
					end
					if (pend_s1 && !done_probe) begin
						n_chk_q <= n_chk_q + 1'b1;
					end
					if (done_probe) begin
						st_q <= lpht_pkg::ST_ACT;
					end
				end
				lpht_pkg::ST_ACT: begin
					if (mode_q == lpht_pkg::MODE_INSERT && !present_q && can_put_q) begin
						valid_q[tgt_addr_q] <= 1'b1;
						cnt_q               <= cnt_q + 1'b1;
					end
					if (mode_q == lpht_pkg::MODE_REMOVE && present_q) begin
						cnt_q <= cnt_q - 1'b1;
					end
					st_q <= lpht_pkg::ST_OUT;
				end
				lpht_pkg::ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						st_q <= lpht_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= lpht_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// request, probe and result payload
	always_ff @(posedge clk) begin
		case (st_q)
			lpht_pkg::ST_IDLE: begin
				if (in_fire) begin
					mode_q       <= lpht_pkg::mode_t'(s_axis_tuser);
					hash_q       <= s_axis_tdata[31:0];
					key_q        <= KEY_WIDTH'(s_axis_tdata[63:32]);
					val_q        <= VALUE_WIDTH'(s_axis_tdata[95:64]);
					rd_addr_q    <= IDXW'(s_axis_tdata[31:0]);
					res_status_q <= lpht_pkg::STATUS_OK;
					res_hit_q    <= 1'b0;
					res_added_q  <= 1'b0;
					res_vout_q   <= '0;
				end
			end
			lpht_pkg::ST_MOD: begin
				case (step_q)
					2'd0: begin
						mulhi_q <= mul_full[63:32];
					end
					2'd1: begin
						quo_q <= 32'(quo_sum >> IDXW);
					end
					default: begin
						rd_addr_q <= hash_q[IDXW-1:0] - quo_mul;
					end
				endcase
			end
			lpht_pkg::ST_PROBE: begin
				if (issue) begin
					addr_s1   <= rd_addr_q;
					vbit_s1   <= valid_q[rd_addr_q];
					rd_addr_q <= rd_addr_inc;
				end
				if (b_tomb && !have_tomb_q) begin
					tomb_addr_q <= addr_s1;
				end
				if (done_probe) begin
					present_q  <= b_match;
					can_put_q  <= b_empty || b_match || have_tomb_q || b_tomb;
					tgt_addr_q <= (b_match || !have_tomb_q) ? addr_s1 : tomb_addr_q;
					word_q     <= rdata;
				end
			end
			lpht_pkg::ST_ACT: begin
				case (mode_q)
					lpht_pkg::MODE_LOOKUP: begin
						res_hit_q    <= present_q;
						res_status_q <= present_q ? lpht_pkg::STATUS_OK :
							lpht_pkg::STATUS_NOT_FOUND;
						res_vout_q   <= present_q ?
							lpht_pkg::FIELD_W'(word_q[VALUE_WIDTH-1:0]) : '0;
					end
					lpht_pkg::MODE_INSERT: begin
						res_hit_q    <= present_q;
						res_added_q  <= !present_q && can_put_q;
						res_status_q <= can_put_q ? lpht_pkg::STATUS_OK : lpht_pkg::STATUS_FULL;
					end
					lpht_pkg::MODE_REMOVE: begin
						res_hit_q <= present_q;
					end
					default: begin
						res_hit_q <= 1'b0;
					end
				endcase
			end
			lpht_pkg::ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					status_q <= res_status_q;
					hit_q    <= res_hit_q;
					added_q  <= res_added_q;
					vout_q   <= res_vout_q;
					live_q   <= lpht_pkg::LIVE_W'(cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (st_q == lpht_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, live_q, vout_q, added_q, hit_q, status_q};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready)
		else $error("request taken while busy");

	a_write_in_act: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (st_q == lpht_pkg::ST_ACT))
		else $error("bucket write outside action step");

	a_added_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(added_q && hit_q))
		else $error("result both added and hit");

endmodule
